[hw/rtl/lru_key_value_cache_defines.svh]
// Assertion macros shared by the LRU key-value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LRU_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LRU_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hw/rtl/lru_kv_pkg.sv]
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lru_kv_pkg;

    // Default number of stack entries.
    localparam int ENTRIES_DEFAULT = 16;

    // Depth of the request queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Capacity register width and reset value.
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request operation codes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // One request as it travels through the queue.
    typedef struct packed {
        logic        operation;
        logic [31:0] key;
        logic [31:0] value;
    } item_t;

    // Status of the back part, seen by the top level.
    typedef struct packed {
        logic busy;
        logic store_empty;
        logic store_full;
    } back_status_t;

endpackage

`default_nettype wire

[hw/rtl/lru_kv_front.sv]
// Front part: accepts request transactions and queues them for the back part.
`default_nettype none

module lru_kv_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              operation,
    input  wire logic [31:0]       lookup_key,
    input  wire logic [31:0]       write_value,
    output logic                   q_valid,
    output lru_kv_pkg::item_t      q_item,
    input  wire logic              q_pop
);

    localparam int DEPTH = lru_kv_pkg::QUEUE_DEPTH;
    localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    lru_kv_pkg::item_t queue_reg [DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;
    logic push;
    lru_kv_pkg::item_t push_item;

    // Classify the incoming request into a queue entry.
    always_comb
    begin
        push_item.operation = (operation == lru_kv_pkg::OP_PUT) ?
                              lru_kv_pkg::OP_PUT : lru_kv_pkg::OP_GET;
        push_item.key       = lookup_key;
        push_item.value     = (operation == lru_kv_pkg::OP_PUT) ? write_value : 32'd0;
    end

    assign in_stall = (fill_reg == NW'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];

    // Pointer and fill count updates with explicit wrap.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lru_kv_back.sv]
// Back part: recency-ordered key stack, lookup sequencer and result register.
`default_nettype none

module lru_kv_back #(
    parameter int ENTRIES = lru_kv_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [lru_kv_pkg::CAP_W-1:0]  cfg_data,
    input  wire logic                          q_valid,
    input  wire lru_kv_pkg::item_t             q_item,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               hit,
    output logic [31:0]                        read_value,
    output logic                               evicted,
    output logic [31:0]                        evicted_key,
    output lru_kv_pkg::back_status_t           status
);

    localparam int PW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [0:0] ST_LOOK = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [lru_kv_pkg::CAP_W-1:0] cap_reg;
    logic [31:0] keys_reg [ENTRIES];
    logic [31:0] vals_reg [ENTRIES];
    lru_kv_pkg::item_t item_reg;
    logic [ENTRIES-1:0] match_reg, match_now;
    logic out_valid_reg, out_valid_next;
    logic hit_reg, evicted_reg;
    logic [31:0] read_value_reg, evicted_key_reg;

    logic go;
    logic hit_w, is_put, ev_w, do_write, full_w;
    logic [PW-1:0] pos_w, last_idx;
    logic [31:0] old_val, ev_key, new_val;
    logic [CW-1:0] eff_cap, count_after, shift_lim;

    // Compare the queue head against every valid stack entry.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_now[i] = (CW'(i) < count_reg) && (keys_reg[i] == q_item.key);
        end
    end

    // Capacity in use, clamped to the range 1 to ENTRIES.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (int'(cap_reg) > ENTRIES)
        begin
            eff_cap = CW'(ENTRIES);
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    assign full_w = (count_reg >= eff_cap);

    // Keys are unique in the stack, so the match vector is one-hot or zero.
    always_comb
    begin
        pos_w    = '0;
        old_val  = '0;
        ev_key   = '0;
        last_idx = PW'(count_reg - 1'b1);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_reg[i])
            begin
                pos_w   = pos_w | PW'(i);
                old_val = old_val | vals_reg[i];
            end
            if (PW'(i) == last_idx)
            begin
                ev_key = ev_key | keys_reg[i];
            end
        end
    end

    // Decide the stack update for the request held in the back part.
    always_comb
    begin
        hit_w    = |match_reg;
        is_put   = (item_reg.operation == lru_kv_pkg::OP_PUT);
        ev_w     = !hit_w && is_put && full_w;
        do_write = hit_w || is_put;
        new_val  = is_put ? item_reg.value : old_val;
        count_after = ev_w ? (count_reg - 1'b1) : count_reg;
        if (hit_w)
        begin
            shift_lim = CW'(pos_w);
        end
        else if (count_after >= CW'(ENTRIES - 1))
        begin
            shift_lim = CW'(ENTRIES - 1);
        end
        else
        begin
            shift_lim = count_after;
        end
    end

    assign go    = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign q_pop = (state_reg == ST_LOOK) && q_valid;

    // Sequencer and entry count.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_LOOK:
            begin
                if (q_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next     = ST_LOOK;
                    out_valid_next = 1'b1;
                    if (!hit_w && is_put && !ev_w && (count_reg < CW'(ENTRIES)))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOOK;
            end
        endcase
        if (cfg_write)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOOK;
            count_reg     <= '0;
            cap_reg       <= lru_kv_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Capture the request and its match vector when it leaves the queue.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg  <= q_item;
            match_reg <= match_now;
        end
    end

    // Move the touched entry to the top and shift the ones above it down.
    always_ff @(posedge clk)
    begin
        if (go && do_write)
        begin
            keys_reg[0] <= item_reg.key;
            vals_reg[0] <= new_val;
            for (int i = 1; i < ENTRIES; i++)
            begin
                if (CW'(i) <= shift_lim)
                begin
                    keys_reg[i] <= keys_reg[i-1];
                    vals_reg[i] <= vals_reg[i-1];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            hit_reg         <= hit_w;
            read_value_reg  <= (hit_w && !is_put) ? old_val : 32'd0;
            evicted_reg     <= ev_w;
            evicted_key_reg <= ev_w ? ev_key : 32'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    assign status.busy        = (state_reg != ST_LOOK) || out_valid_reg;
    assign status.store_empty = (count_reg == '0);
    assign status.store_full  = full_w;

endmodule

`default_nettype wire

[hw/rtl/lru_key_value_cache.sv]
// Top level of the LRU key-value cache: front queue feeding the stack back part.
//
//  Channel   Handshake             Payload
//  -------   -------------------   ---------------------------------------------
//  in        in_valid / in_stall   operation, lookup_key, write_value
//  out       out_valid / out_stall hit, read_value, evicted, evicted_key
//  cfg       cfg_write             cfg_data (capacity_in_use)
//
// In the back part, the look state compares the key against every stack entry and
// the execute state shifts the stack and loads the result register.
// A two-entry queue in front accepts transactions while the back part works.
// Reset empties the store and sets the capacity to 16; a capacity write also
// empties the store. A stalled result holds the back part in its execute state.
`default_nettype none

`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
    parameter int ENTRIES = lru_kv_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [lru_kv_pkg::CAP_W-1:0]  cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          operation,
    input  wire logic [31:0]                   lookup_key,
    input  wire logic [31:0]                   write_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               hit,
    output logic [31:0]                        read_value,
    output logic                               evicted,
    output logic [31:0]                        evicted_key
);

    logic q_valid;
    logic q_pop;
    lru_kv_pkg::item_t q_item;
    lru_kv_pkg::back_status_t status;

    lru_kv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    lru_kv_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .status      (status)
    );

    // A capacity write leaves the store empty.
    `LRU_ASSERT_NEXT(a_cfg_clears, cfg_write, status.store_empty, "store not cleared")

    // The capacity in use is at least one, so an empty store is never full.
    `LRU_ASSERT_NOW(a_empty_not_full, status.store_empty, !status.store_full, "full while empty")

    // Only a miss can evict.
    `LRU_ASSERT_NOW(a_evict_on_miss, out_valid, !(hit && evicted), "eviction reported on a hit")

    // A miss returns no value.
    `LRU_ASSERT_NOW(a_miss_no_value, out_valid && !hit, read_value == 32'd0, "miss returned a value")

    // A waiting result keeps the back part busy.
    `LRU_ASSERT_NOW(a_result_busy, out_valid, status.busy, "result pending while idle")

endmodule

`default_nettype wire
